### rtl/kas_pkg.sv
package kas_pkg;

  // Key table size and field widths
  localparam int NUM_KEYS          = 14;
  localparam int KEY_W             = 4;
  localparam int WORD_W            = 32;
  localparam int DELAY_W           = 16;
  localparam int PULSE_W           = 16;
  localparam int PULSE_COUNT_WIDTH = 16;

  // Configuration port geometry
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes, taken from paddr[2]
  localparam logic REG_FIRST_DELAY  = 1'b0;
  localparam logic REG_REPEAT_DELAY = 1'b1;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RESET  = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RESET = 16'd175;

  localparam logic [WORD_W-1:0] REMOTE_BIT = 32'h0004_0000;

  // Key groups: which button word a key lives in
  localparam logic GROUP_ONE = 1'b0;
  localparam logic GROUP_TWO = 1'b1;

  localparam logic [NUM_KEYS-1:0] KEY_GROUP = {
    GROUP_TWO, GROUP_TWO, GROUP_TWO, GROUP_TWO, GROUP_TWO, GROUP_TWO, GROUP_TWO,
    GROUP_TWO, GROUP_TWO, GROUP_ONE, GROUP_ONE, GROUP_ONE, GROUP_ONE, GROUP_ONE
  };

  localparam logic [WORD_W-1:0] KEY_MASK [NUM_KEYS] = '{
    32'h0100_0000, 32'h0200_0000, 32'h0400_0000, 32'h0800_0000, 32'h1000_0000,
    32'h0000_0010, 32'h0000_0020, 32'h0000_0100, 32'h0000_0200, 32'h0000_0400,
    32'h0000_0800, 32'h0000_000c, 32'h0000_0008, 32'h0000_0004
  };

  typedef struct packed {
    logic [WORD_W-1:0] button_word_one;
    logic [WORD_W-1:0] button_word_two;
    logic [WORD_W-1:0] tick_ms;
    logic              clear_repeat;
  } kas_scan_t;

  typedef struct packed {
    logic [KEY_W-1:0]   pressed_key;
    logic [KEY_W-1:0]   clicked_key;
    logic [KEY_W-1:0]   repeat_key;
    logic               usb_level;
    logic [PULSE_W-1:0] usb_pulse_scans;
  } kas_result_t;

  typedef struct packed {
    logic [DELAY_W-1:0] first_delay_ms;
    logic [DELAY_W-1:0] repeat_delay_ms;
  } kas_cfg_t;

  // One bit per key: all mask bits low in its word
  function automatic logic [NUM_KEYS-1:0] keys_down(input logic [WORD_W-1:0] w1,
                                                     input logic [WORD_W-1:0] w2);
    logic [NUM_KEYS-1:0] down;
    down = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (KEY_GROUP[i] == GROUP_ONE) begin
        down[i] = ((w1 & KEY_MASK[i]) == '0);
      end else begin
        down[i] = ((w2 & KEY_MASK[i]) == '0);
      end
    end
    return down;
  endfunction

  // Lowest set bit as a 1-based key number, 0 if none
  function automatic logic [KEY_W-1:0] first_key(input logic [NUM_KEYS-1:0] vec);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        key = KEY_W'(i + 1);
      end
    end
    return key;
  endfunction

endpackage

### rtl/kas_in_if.sv
interface kas_in_if;
  import kas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [WORD_W-1:0]     button_word_one;
  logic [WORD_W-1:0]     button_word_two;
  logic [WORD_W-1:0]     tick_ms;
  logic                  clear_repeat;

  modport source (
    output valid, button_word_one, button_word_two, tick_ms, clear_repeat,
    input  ready
  );

  modport sink (
    input  valid, button_word_one, button_word_two, tick_ms, clear_repeat,
    output ready
  );
endinterface

### rtl/kas_out_if.sv
interface kas_out_if;
  import kas_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [KEY_W-1:0]      pressed_key;
  logic [KEY_W-1:0]      clicked_key;
  logic [KEY_W-1:0]      repeat_key;
  logic                  usb_level;
  logic [PULSE_W-1:0]    usb_pulse_scans;

  modport source (
    output valid, pressed_key, clicked_key, repeat_key, usb_level, usb_pulse_scans,
    input  ready
  );

  modport sink (
    input  valid, pressed_key, clicked_key, repeat_key, usb_level, usb_pulse_scans,
    output ready
  );
endinterface

### rtl/kas_cfg_regs.sv
module kas_cfg_regs
  import kas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output kas_cfg_t              cfg
);

  logic [DELAY_W-1:0] first_delay_r;
  logic [DELAY_W-1:0] repeat_delay_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // Register writes, low 16 bits kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r  <= FIRST_DELAY_RESET;
      repeat_delay_r <= REPEAT_DELAY_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FIRST_DELAY:  first_delay_r  <= pwdata[DELAY_W-1:0];
        REG_REPEAT_DELAY: repeat_delay_r <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_FIRST_DELAY:  prdata = APB_DATA_W'(first_delay_r);
      REG_REPEAT_DELAY: prdata = APB_DATA_W'(repeat_delay_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.first_delay_ms  = first_delay_r;
  assign cfg.repeat_delay_ms = repeat_delay_r;

endmodule

### rtl/kas_scan_core.sv
module kas_scan_core
  import kas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  kas_scan_t   scan,
  input  logic        scan_fire,
  input  kas_cfg_t    cfg,
  output kas_result_t result
);

  logic [WORD_W-1:0]            prev_word_one_r;
  logic [WORD_W-1:0]            prev_word_two_r;
  logic [KEY_W-1:0]             held_key_r, held_key_nxt;
  logic                         repeating_r, repeating_nxt;
  logic [WORD_W-1:0]            last_time_r, last_time_nxt;
  logic [PULSE_COUNT_WIDTH-1:0] usb_cnt_r, usb_cnt_nxt;

  logic [NUM_KEYS-1:0] down_now;
  logic [NUM_KEYS-1:0] down_prev;
  logic [15:0]         down_pad;
  logic [KEY_W-1:0]    pressed;
  logic [KEY_W-1:0]    clicked;
  logic [KEY_W-1:0]    held_eff;
  logic [KEY_W-1:0]    rep;
  logic                held_down;
  logic [WORD_W-1:0]   elapsed;
  logic [DELAY_W-1:0]  delay;
  logic                level;
  logic [PULSE_W-1:0]  pulse;

  // Key decode and priority encoders
  always_comb begin
    down_now  = keys_down(scan.button_word_one, scan.button_word_two);
    down_prev = keys_down(prev_word_one_r, prev_word_two_r);
    pressed   = first_key(down_now);
    clicked   = first_key(down_now & ~down_prev);
    down_pad  = {2'b00, down_now};
  end

  // Click / autorepeat / release
  always_comb begin
    held_eff      = scan.clear_repeat ? '0 : held_key_r;
    held_down     = (held_eff != '0) && down_pad[held_eff - KEY_W'(1)];
    elapsed       = scan.tick_ms - last_time_r;
    delay         = repeating_r ? cfg.repeat_delay_ms : cfg.first_delay_ms;
    held_key_nxt  = held_eff;
    repeating_nxt = repeating_r;
    last_time_nxt = last_time_r;
    rep           = '0;
    if (clicked != '0) begin
      held_key_nxt  = clicked;
      repeating_nxt = 1'b0;
      last_time_nxt = scan.tick_ms;
      rep           = clicked;
    end else if (held_down) begin
      if (elapsed > WORD_W'(delay)) begin
        repeating_nxt = 1'b1;
        last_time_nxt = scan.tick_ms;
        rep           = held_eff;
      end
    end else begin
      held_key_nxt = '0;
    end
  end

  // Remote pulse counter, saturating
  always_comb begin
    level       = (scan.button_word_two & REMOTE_BIT) == REMOTE_BIT;
    usb_cnt_nxt = usb_cnt_r;
    pulse       = '0;
    if (level) begin
      if (usb_cnt_r != '1) begin
        usb_cnt_nxt = usb_cnt_r + PULSE_COUNT_WIDTH'(1);
      end
    end else if (usb_cnt_r != '0) begin
      pulse       = (32'(usb_cnt_r) > 32'h0000_FFFF) ? '1 : PULSE_W'(usb_cnt_r);
      usb_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_word_one_r <= '1;
      prev_word_two_r <= '1;
      held_key_r      <= '0;
      repeating_r     <= 1'b0;
      last_time_r     <= '0;
      usb_cnt_r       <= '0;
    end else if (scan_fire) begin
      prev_word_one_r <= scan.button_word_one;
      prev_word_two_r <= scan.button_word_two;
      held_key_r      <= held_key_nxt;
      repeating_r     <= repeating_nxt;
      last_time_r     <= last_time_nxt;
      usb_cnt_r       <= usb_cnt_nxt;
    end
  end

  assign result.pressed_key     = pressed;
  assign result.clicked_key     = clicked;
  assign result.repeat_key      = rep;
  assign result.usb_level       = level;
  assign result.usb_pulse_scans = pulse;

endmodule

### rtl/keypad_autorepeat_scanner.sv
// Channel   Dir  Handshake          Carries
// in_ch     in   valid/ready        button words, tick_ms, clear_repeat
// out_ch    out  valid/ready        pressed, clicked, repeat key, usb level/pulse
// APB       in   psel/penable/pwr   first/repeat delay at 0x0 / 0x4
//
// An item enters the input register, is evaluated combinationally and lands in
// the result register; one item per cycle is sustained while out_ch does not stall.
// rst_n is synchronous; it clears both stages and restores register defaults.
// When out_ch stalls, the input register holds one more item before in_ch stalls.
module keypad_autorepeat_scanner
  import kas_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  kas_in_if.sink                in_ch,
  kas_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  kas_cfg_t    cfg;
  kas_scan_t   scan_r;
  logic        scan_valid_r;
  kas_result_t result;
  kas_result_t result_r;
  logic        out_valid_r;
  logic        advance;
  logic        scan_fire;
  logic        in_fire;

  kas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow control
  assign advance     = !out_valid_r || out_ch.ready;
  assign scan_fire   = scan_valid_r && advance;
  assign in_ch.ready = !scan_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      scan_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      scan_r.button_word_one <= in_ch.button_word_one;
      scan_r.button_word_two <= in_ch.button_word_two;
      scan_r.tick_ms         <= in_ch.tick_ms;
      scan_r.clear_repeat    <= in_ch.clear_repeat;
    end
  end

  kas_scan_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .scan      (scan_r),
    .scan_fire (scan_fire),
    .cfg       (cfg),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= scan_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_fire) begin
      result_r <= result;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pressed_key     = result_r.pressed_key;
  assign out_ch.clicked_key     = result_r.clicked_key;
  assign out_ch.repeat_key      = result_r.repeat_key;
  assign out_ch.usb_level       = result_r.usb_level;
  assign out_ch.usb_pulse_scans = result_r.usb_pulse_scans;

endmodule
